[rtl/gsl_pkg.sv]
// ----------------------------------------------------------------------------
// Grammar specification lexer package
// Shared types, character constants and character class functions.
// ----------------------------------------------------------------------------
package gsl_pkg;

  typedef enum logic [7:0] {
    M_START = 8'b0000_0001,
    M_COLON = 8'b0000_0010,
    M_IDENT = 8'b0000_0100,
    M_QUOTE = 8'b0000_1000,
    M_NL    = 8'b0001_0000,
    M_NLP   = 8'b0010_0000,
    M_NLPP  = 8'b0100_0000,
    M_HALT  = 8'b1000_0000
  } mode_t;

  typedef enum logic [2:0] {
    EV_IDCHAR  = 3'd0,
    EV_CTCHAR  = 3'd1,
    EV_IDEND   = 3'd2,
    EV_CTEND   = 3'd3,
    EV_TRANSIT = 3'd4,
    EV_NEWLINE = 3'd5,
    EV_ENDFILE = 3'd6,
    EV_ERROR   = 3'd7
  } ev_t;

  typedef enum logic [1:0] {
    ERR_EOF     = 2'd0,
    ERR_INVALID = 2'd1,
    ERR_QUOTE   = 2'd2
  } err_t;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] CH_EQUAL   = 8'h3D;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [15:0] LINE_MAX  = 16'hFFFF;

  typedef struct packed {
    ev_t         ev;
    logic [7:0]  ch;
    err_t        err;
    logic [15:0] line;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
    mode_t      mode;
    logic       line_inc;
  } step_t;

  function automatic logic is_letter(input logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return (b == 8'h20) || (b == 8'h09) || (b == 8'h0B) || (b == 8'h0C) || (b == 8'h0D);
  endfunction

  function automatic res_t mk_res(input ev_t ev, input logic [7:0] ch, input err_t err,
                                  input logic [15:0] line);
    res_t r;
    r.ev   = ev;
    r.ch   = ch;
    r.err  = err;
    r.line = line;
    r.last = 1'b0;
    return r;
  endfunction

endpackage

[rtl/gsl_step.sv]
// ----------------------------------------------------------------------------
// Grammar specification lexer step logic
// Computes the results, next mode and line increment for one input byte.
// ----------------------------------------------------------------------------
module gsl_step (
  input  gsl_pkg::mode_t  mode_i,
  input  logic [7:0]      byte_i,
  input  logic [15:0]     line_i,
  output gsl_pkg::step_t  step_o
);
  import gsl_pkg::*;

  logic  st_emit;
  res_t  st_res;
  mode_t st_mode;
  logic  st_inc;
  res_t  a_res;
  logic  a_emit;
  logic  use_start;
  step_t s;

  always_comb begin
    st_emit = 1'b0;
    st_res  = mk_res(EV_ERROR, 8'h00, ERR_INVALID, line_i);
    st_mode = M_START;
    st_inc  = 1'b0;
    if (is_blank(byte_i)) begin
      st_mode = M_START;
    end else if (byte_i == CH_NUL) begin
      st_emit = 1'b1;
      st_res  = mk_res(EV_ERROR, 8'h00, ERR_EOF, line_i);
      st_mode = M_HALT;
    end else if (byte_i == CH_COLON) begin
      st_mode = M_COLON;
    end else if (byte_i == CH_NL) begin
      st_inc  = (line_i != LINE_MAX);
      st_mode = M_NL;
    end else if (byte_i == CH_QUOTE) begin
      st_mode = M_QUOTE;
    end else if (is_letter(byte_i)) begin
      st_emit = 1'b1;
      st_res  = mk_res(EV_IDCHAR, byte_i, ERR_EOF, line_i);
      st_mode = M_IDENT;
    end else begin
      st_emit = 1'b1;
      st_mode = M_HALT;
    end
  end

  always_comb begin
    a_emit    = 1'b0;
    a_res     = mk_res(EV_NEWLINE, 8'h00, ERR_EOF, line_i);
    use_start = 1'b0;
    s.mode    = mode_i;
    unique case (mode_i)
      M_START: begin
        use_start = 1'b1;
      end
      M_COLON: begin
        if (byte_i == CH_EQUAL) begin
          a_emit = 1'b1;
          a_res  = mk_res(EV_TRANSIT, 8'h00, ERR_EOF, line_i);
          s.mode = M_START;
        end else begin
          a_emit = 1'b1;
          a_res  = mk_res(EV_ERROR, 8'h00, ERR_INVALID, line_i);
          s.mode = M_HALT;
        end
      end
      M_IDENT: begin
        a_emit = 1'b1;
        if (is_letter(byte_i) || is_digit(byte_i)) begin
          a_res = mk_res(EV_IDCHAR, byte_i, ERR_EOF, line_i);
        end else begin
          a_res     = mk_res(EV_IDEND, 8'h00, ERR_EOF, line_i);
          use_start = 1'b1;
        end
      end
      M_QUOTE: begin
        a_emit = 1'b1;
        if (byte_i == CH_QUOTE) begin
          a_res  = mk_res(EV_CTEND, 8'h00, ERR_EOF, line_i);
          s.mode = M_START;
        end else if ((byte_i == CH_NUL) || byte_i[7]) begin
          a_res  = mk_res(EV_ERROR, 8'h00, ERR_QUOTE, line_i);
          s.mode = M_HALT;
        end else begin
          a_res = mk_res(EV_CTCHAR, byte_i, ERR_EOF, line_i);
        end
      end
      M_NL: begin
        if (byte_i == CH_PERCENT) begin
          s.mode = M_NLP;
        end else begin
          a_emit    = 1'b1;
          use_start = 1'b1;
        end
      end
      M_NLP: begin
        if (byte_i == CH_PERCENT) begin
          s.mode = M_NLPP;
        end else begin
          a_emit = 1'b1;
          s.mode = M_HALT;
        end
      end
      M_NLPP: begin
        a_emit = 1'b1;
        if (byte_i == CH_NL) begin
          a_res  = mk_res(EV_ENDFILE, 8'h00, ERR_EOF, line_i);
          s.mode = M_START;
        end else begin
          s.mode = M_HALT;
        end
      end
      default: begin
        s.mode = M_HALT;
      end
    endcase

    s.line_inc = 1'b0;
    s.r0       = a_res;
    s.r1       = st_res;
    s.cnt      = {1'b0, a_emit};

    if (((mode_i == M_NLP) || (mode_i == M_NLPP)) && (s.mode == M_HALT)) begin
      s.r1  = mk_res(EV_ERROR, 8'h00, ERR_INVALID, line_i);
      s.cnt = 2'd2;
    end

    if (use_start) begin
      s.mode     = st_mode;
      s.line_inc = st_inc;
      if (a_emit) begin
        s.r1  = st_res;
        s.cnt = st_emit ? 2'd2 : 2'd1;
      end else begin
        s.r0  = st_res;
        s.cnt = {1'b0, st_emit};
      end
    end

    if (s.cnt == 2'd1) begin
      s.r0.last = 1'b1;
    end
    if (s.cnt == 2'd2) begin
      s.r1.last = 1'b1;
    end
    step_o = s;
  end

endmodule

[rtl/grammar_spec_lexer.sv]
// ----------------------------------------------------------------------------
// Grammar specification lexer
// Byte-serial lexer for grammar specification text with line counting.
// ----------------------------------------------------------------------------
// The input channel carries one character per transaction; a zero byte marks
// the end of input. Each byte gives zero, one or two result transactions on
// the output channel: lexeme characters, token ends, transit, newline,
// endfile or an error, each with the current line number. out_tuser carries
// the event kind, and out_tlast marks the last result caused by one input byte.
// An accepted byte sits in an input register, is lexed there, and its results
// are written into a four-entry result queue and offered from its head. One
// byte is taken per cycle while the queue has room for two results; bytes that
// give two results can stall the input when the receiver is slow.
// When the receiver stalls, the queue fills and in_tready drops; nothing is
// lost. Reset clears the queue, returns the lexer to its start state and
// loads the line counter with 1. A cfg_wr_en write loads the line counter.
// After an error every further byte is consumed without a result until reset.
// ----------------------------------------------------------------------------
module grammar_spec_lexer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] in_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // [7:0] char_value, [9:8] error_code,
                                   // [25:10] line_number
  output logic [2:0]  out_tuser,   // [2:0] event_res
  output logic        out_tlast
);
  import gsl_pkg::*;

  logic        in_vld_r;
  logic [7:0]  in_byte_r;
  mode_t       mode_r;
  logic [15:0] line_r;
  res_t        q_r [4];
  logic [1:0]  wr_ptr_r;
  logic [1:0]  rd_ptr_r;
  logic [2:0]  cnt_r;
  step_t       step;
  logic        proc;
  logic        pop;
  logic [1:0]  push;
  res_t        head;

  gsl_step u_step (
    .mode_i (mode_r),
    .byte_i (in_byte_r),
    .line_i (line_r),
    .step_o (step)
  );

  assign proc      = in_vld_r && (cnt_r <= 3'd2);
  assign in_tready = !in_vld_r || proc;
  assign push      = proc ? step.cnt : 2'd0;
  assign head      = q_r[rd_ptr_r];
  assign out_tvalid = (cnt_r != 3'd0);
  assign pop       = out_tvalid && out_tready;
  assign out_tdata = {6'b000000, head.line, head.err, head.ch};
  assign out_tuser = head.ev;
  assign out_tlast = head.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      mode_r   <= M_START;
      line_r   <= 16'd1;
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      cnt_r    <= 3'd0;
    end else begin
      if (in_tready) begin
        in_vld_r <= in_tvalid;
      end
      if (proc) begin
        mode_r <= step.mode;
      end
      if (cfg_wr_en) begin
        line_r <= cfg_wr_data;
      end else if (proc && step.line_inc) begin
        line_r <= line_r + 16'd1;
      end
      wr_ptr_r <= wr_ptr_r + push;
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 2'd1;
      end
      cnt_r <= cnt_r + {1'b0, push} - {2'b00, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      in_byte_r <= in_tdata;
    end
    if (push != 2'd0) begin
      q_r[wr_ptr_r] <= step.r0;
    end
    if (push == 2'd2) begin
      q_r[wr_ptr_r + 2'd1] <= step.r1;
    end
  end

endmodule

[sim/grammar_spec_lexer_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Grammar specification lexer testbench
// Sends a directed byte sequence and then phases of random well-formed token
// text through the input stream, with the start line changed between phases.
// A scoreboard predicts every result transaction and checks each one in order.
// One error sequence at the end halts the lexer, and random bytes that follow
// must give no result.
// ----------------------------------------------------------------------------
module grammar_spec_lexer_tb;
  import gsl_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 10;
  localparam int PHASE_BYTES  = 190;

  class token_scoreboard;
    mode_t       mode;
    logic [15:0] line_cnt;
    res_t        tokens_due[$];
    res_t        byte_events[$];
    int          mismatches;

    function new();
      mode = M_START;
      line_cnt = 16'd1;
      mismatches = 0;
    endfunction

    function void load_line(logic [15:0] v);
      line_cnt = v;
    endfunction

    function bit alpha_ch(logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function bit digit_ch(logic [7:0] b);
      return b >= "0" && b <= "9";
    endfunction

    function bit blank_ch(logic [7:0] b);
      return b == 8'h20 || b == 8'h09 || b == 8'h0B || b == 8'h0C || b == 8'h0D;
    endfunction

    function void add_event(ev_t ev, logic [7:0] ch, err_t err);
      res_t r;
      r.ev = ev;
      r.ch = ch;
      r.err = err;
      r.line = line_cnt;
      r.last = 1'b0;
      if (byte_events.size() < 2) byte_events.insert(byte_events.size(), r);
    endfunction

    function void halt_with(err_t err);
      add_event(EV_ERROR, 8'h00, err);
      mode = M_HALT;
    endfunction

    function void lex_fresh(logic [7:0] b);
      if (blank_ch(b)) begin
      end else if (b == CH_NUL) begin
        halt_with(ERR_EOF);
      end else if (b == CH_COLON) begin
        mode = M_COLON;
      end else if (b == CH_NL) begin
        if (line_cnt != LINE_MAX) line_cnt = line_cnt + 16'd1;
        mode = M_NL;
      end else if (b == CH_QUOTE) begin
        mode = M_QUOTE;
      end else if (alpha_ch(b)) begin
        add_event(EV_IDCHAR, b, ERR_EOF);
        mode = M_IDENT;
      end else begin
        halt_with(ERR_INVALID);
      end
    endfunction

    function void lex_byte(logic [7:0] b);
      res_t r;
      byte_events.delete();
      case (mode)
        M_START: lex_fresh(b);
        M_COLON: begin
          if (b == CH_EQUAL) begin
            add_event(EV_TRANSIT, 8'h00, ERR_EOF);
            mode = M_START;
          end else begin
            halt_with(ERR_INVALID);
          end
        end
        M_IDENT: begin
          if (alpha_ch(b) || digit_ch(b)) begin
            add_event(EV_IDCHAR, b, ERR_EOF);
          end else begin
            add_event(EV_IDEND, 8'h00, ERR_EOF);
            mode = M_START;
            lex_fresh(b);
          end
        end
        M_QUOTE: begin
          if (b == CH_QUOTE) begin
            add_event(EV_CTEND, 8'h00, ERR_EOF);
            mode = M_START;
          end else if (b == CH_NUL || b[7]) begin
            halt_with(ERR_QUOTE);
          end else begin
            add_event(EV_CTCHAR, b, ERR_EOF);
          end
        end
        M_NL: begin
          if (b == CH_PERCENT) begin
            mode = M_NLP;
          end else begin
            add_event(EV_NEWLINE, 8'h00, ERR_EOF);
            mode = M_START;
            lex_fresh(b);
          end
        end
        M_NLP: begin
          if (b == CH_PERCENT) begin
            mode = M_NLPP;
          end else begin
            add_event(EV_NEWLINE, 8'h00, ERR_EOF);
            halt_with(ERR_INVALID);
          end
        end
        M_NLPP: begin
          if (b == CH_NL) begin
            add_event(EV_ENDFILE, 8'h00, ERR_EOF);
            mode = M_START;
          end else begin
            add_event(EV_NEWLINE, 8'h00, ERR_EOF);
            halt_with(ERR_INVALID);
          end
        end
        default: begin
        end
      endcase
      if (byte_events.size() > 0) begin
        r = byte_events[byte_events.size() - 1];
        r.last = 1'b1;
        byte_events[byte_events.size() - 1] = r;
      end
      foreach (byte_events[i]) tokens_due.insert(tokens_due.size(), byte_events[i]);
    endfunction

    task report_mismatch(string what, int got, int want);
      mismatches++;
      if (mismatches <= 50) begin
        $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
      end
    endtask

    task check_token(logic [31:0] data, logic [2:0] kind, logic last);
      res_t want;
      if (tokens_due.size() == 0) begin
        report_mismatch("unexpected result, tdata", data, 0);
      end else begin
        want = tokens_due.pop_front();
        if (kind != want.ev) report_mismatch("event_res", kind, want.ev);
        if (data[7:0] != want.ch) report_mismatch("char_value", data[7:0], want.ch);
        if (data[9:8] != want.err) report_mismatch("error_code", data[9:8], want.err);
        if (data[25:10] != want.line) report_mismatch("line_number", data[25:10], want.line);
        if (data[31:26] != 6'b000000) report_mismatch("tdata padding", data[31:26], 0);
        if (last !== want.last) report_mismatch("tlast", last, want.last);
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  token_scoreboard tokens = new();
  int          bytes_sent = 0;
  int          burst_left = 0;
  int          cycle_count = 0;
  logic [7:0]  blank_set[5] = '{8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0D};
  string       bad_chars = "#%=09!;}~@";

  grammar_spec_lexer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL grammar_spec_lexer");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      tokens.check_token(out_tdata, out_tuser, out_tlast);
    end
  end

  initial begin : receiver
    int seg_left;
    int seg_kind;
    int hold_left;
    bit hold_done;
    seg_left = 0;
    seg_kind = 0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (!hold_done && bytes_sent >= 450) begin
        hold_done = 1'b1;
        hold_left = 250;
        out_tready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_kind = $urandom_range(0, 3);
          seg_left = $urandom_range(10, 120);
        end
        seg_left--;
        case (seg_kind)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 3) != 0);
          2: out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= ~out_tready;
        endcase
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tokens.lex_byte(b);
    bytes_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                : $urandom_range(1, 20);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (tokens.tokens_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_first_line(input logic [15:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    tokens.load_line(v);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_fragment();
    int kind;
    int n;
    logic [7:0] c;
    kind = $urandom_range(0, 15);
    if (kind < 5) begin
      send_byte(($urandom_range(0, 1) ? "a" : "A") + 8'($urandom_range(0, 25)));
      n = $urandom_range(0, 8);
      repeat (n) begin
        if ($urandom_range(0, 3) == 0) c = "0" + 8'($urandom_range(0, 9));
        else c = ($urandom_range(0, 1) ? "a" : "A") + 8'($urandom_range(0, 25));
        send_byte(c);
      end
    end else if (kind < 8) begin
      send_byte(CH_QUOTE);
      n = $urandom_range(0, 10);
      repeat (n) begin
        c = 8'($urandom_range(1, 126));
        if (c >= CH_QUOTE) c = c + 8'd1;
        send_byte(c);
      end
      send_byte(CH_QUOTE);
    end else if (kind < 10) begin
      send_byte(CH_COLON);
      send_byte(CH_EQUAL);
    end else if (kind < 13) begin
      n = $urandom_range(1, 3);
      repeat (n) send_byte(blank_set[$urandom_range(0, 4)]);
    end else if (kind < 15) begin
      send_byte(CH_NL);
    end else begin
      send_byte(CH_NL);
      send_byte(CH_PERCENT);
      send_byte(CH_PERCENT);
      send_byte(CH_NL);
    end
  endtask

  task automatic send_breakage();
    logic [7:0] c;
    send_byte(8'h20);
    case ($urandom_range(0, 6))
      0: send_byte(CH_NUL);
      1: send_byte(8'($urandom_range(128, 255)));
      2: send_byte(bad_chars[$urandom_range(0, bad_chars.len() - 1)]);
      3: begin
        c = 8'($urandom_range(0, 255));
        if (c == CH_EQUAL) c = CH_NUL;
        send_byte(CH_COLON);
        send_byte(c);
      end
      4: begin
        send_byte(CH_QUOTE);
        send_text("ab");
        send_byte($urandom_range(0, 1) ? CH_NUL : 8'($urandom_range(128, 255)));
      end
      5: begin
        c = 8'($urandom_range(0, 255));
        if (c == CH_PERCENT) c = CH_NUL;
        send_byte(CH_NL);
        send_byte(CH_PERCENT);
        send_byte(c);
      end
      default: begin
        c = 8'($urandom_range(0, 255));
        if (c == CH_NL) c = 8'hFF;
        send_byte(CH_NL);
        send_byte(CH_PERCENT);
        send_byte(CH_PERCENT);
        send_byte(c);
      end
    endcase
  endtask

  initial begin : stimulus
    logic [15:0] start_lines[6];
    int phase_start;
    start_lines[0] = 16'($urandom);
    start_lines[1] = 16'h0000;
    start_lines[2] = 16'hFFFF;
    start_lines[3] = 16'hFFFE;
    start_lines[4] = 16'h0001;
    start_lines[5] = 16'($urandom);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_text("Ab9 \"q");
    send_byte(CH_NL);
    send_byte(CH_PERCENT);
    send_byte(8'h7F);
    send_byte(8'h01);
    send_text("\":=\t");
    send_byte(8'h0D);
    send_byte(8'h0B);
    send_byte(8'h0C);
    send_byte(CH_NL);
    send_byte(CH_PERCENT);
    send_byte(CH_PERCENT);
    send_byte(CH_NL);
    send_text("z\"\"");
    send_byte(CH_NL);
    send_byte(CH_NL);
    wait_drained();

    foreach (start_lines[p]) begin
      write_first_line(start_lines[p]);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) send_fragment();
      wait_drained();
    end

    send_breakage();
    send_byte(8'hFF);
    send_byte(CH_NUL);
    repeat (40) send_byte(8'($urandom_range(0, 255)));
    wait_drained();

    if (tokens.mismatches == 0 && tokens.tokens_due.size() == 0) begin
      $display("PASS grammar_spec_lexer");
    end else begin
      $display("FAIL grammar_spec_lexer");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/gsl_pkg.sv
rtl/gsl_step.sv
rtl/grammar_spec_lexer.sv
sim/grammar_spec_lexer_tb.sv
